/* hw/rtl/sjis_to_utf8_stream_assert.svh */
// Assertion macros shared by the converter's modules.
// Each macro expects signals named clock and reset in the module that uses it.
`ifndef SJIS_TO_UTF8_STREAM_ASSERT_SVH
`define SJIS_TO_UTF8_STREAM_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication
`define S2U_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication
`define S2U_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define S2U_ASSERT_NOW(lbl, ante, cons, msg)
`define S2U_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* hw/rtl/s2u_pkg.sv */
`default_nettype none

package s2u_pkg;

   // Table geometry defaults
   localparam int TableEntries  = 65536;
   localparam int CodePointBits = 21;

   // Field widths
   localparam int DataBits    = 8;
   localparam int IndexBits   = 16;
   localparam int ValueBits   = 21;
   localparam int StatusBits  = 2;
   localparam int ReqDataBits = 48;

   // Request kinds carried in req_tuser
   localparam logic REQ_CONVERT = 1'b0;
   localparam logic REQ_WRITE   = 1'b1;

   // Result status codes carried in rsp_tuser
   localparam logic [StatusBits-1:0] ST_OK    = 2'd0;
   localparam logic [StatusBits-1:0] ST_TRUNC = 2'd1;
   localparam logic [StatusBits-1:0] ST_RANGE = 2'd2;

   // SJIS byte classes
   localparam logic [DataBits-1:0] LeadLoA   = 8'h81;
   localparam logic [DataBits-1:0] LeadHiA   = 8'h9f;
   localparam logic [DataBits-1:0] LeadLoB   = 8'he0;
   localparam logic [DataBits-1:0] LeadHiB   = 8'hef;
   localparam logic [DataBits-1:0] CtrlLimit = 8'h20;
   localparam logic [DataBits-1:0] DelByte   = 8'h7f;

   // UTF-8 encoding limits and prefixes
   localparam logic [ValueBits-1:0] Max1Byte     = 21'h00007f;
   localparam logic [ValueBits-1:0] Max2Byte     = 21'h0007ff;
   localparam logic [ValueBits-1:0] Max3Byte     = 21'h00ffff;
   localparam logic [ValueBits-1:0] MaxCodePoint = 21'h10ffff;
   localparam logic [DataBits-1:0]  Pfx2Byte     = 8'hc0;
   localparam logic [DataBits-1:0]  Pfx3Byte     = 8'he0;
   localparam logic [DataBits-1:0]  Pfx4Byte     = 8'hf0;
   localparam logic [DataBits-1:0]  PfxCont      = 8'h80;

   // What the word in the lookup stage turns into
   typedef enum logic [1:0] {
      KIND_LOOKUP,
      KIND_LITERAL,
      KIND_TRUNC
   } kind_type;

   // Lookup stage handed from front end to encoder
   typedef struct packed {
      logic                valid;
      kind_type            kind;
      logic [DataBits-1:0] literal;
   } stage_type;

endpackage

`default_nettype wire

/* hw/rtl/s2u_ram.sv */
`default_nettype none

module s2u_ram #(
   parameter int WIDTH = 21,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Registered read; data holds while re is low
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* hw/rtl/s2u_front.sv */
`default_nettype none

module s2u_front #(
   parameter int ADDR_BITS = 16,
   parameter int CP_BITS   = 21
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [s2u_pkg::ReqDataBits-1:0] req_tdata,
   input  wire logic                          req_tlast,
   input  wire logic                          req_tuser,
   output s2u_pkg::stage_type                 stage,
   input  wire logic                          stage_take,
   output logic                               ram_we,
   output logic      [ADDR_BITS-1:0]          ram_waddr,
   output logic      [CP_BITS-1:0]            ram_wdata,
   output logic                               ram_re,
   output logic      [ADDR_BITS-1:0]          ram_raddr
);

   import s2u_pkg::*;

   `include "sjis_to_utf8_stream_assert.svh"

   logic [DataBits-1:0]  data_byte;
   logic [IndexBits-1:0] table_index;
   logic [ValueBits-1:0] table_value;
   logic                 accept;
   logic                 convert;
   logic                 is_lead;
   logic                 is_ctrl;
   logic [IndexBits-1:0] look_index;

   stage_type            stage_ff, stage_in;
   logic                 pend_ff, pend_in;
   logic [DataBits-1:0]  held_ff, held_in;

   // Unpack the request word
   assign data_byte   = req_tdata[DataBits-1:0];
   assign table_index = req_tdata[DataBits+IndexBits-1:DataBits];
   assign table_value = req_tdata[DataBits+IndexBits+ValueBits-1:DataBits+IndexBits];

   // Take a word whenever the lookup stage is free or moving on
   assign req_tready = !stage_ff.valid || stage_take;
   assign accept     = req_tvalid && req_tready;
   assign convert    = accept && (req_tuser == REQ_CONVERT);

   // Classify the byte
   assign is_lead = ((data_byte >= LeadLoA) && (data_byte <= LeadHiA)) ||
                    ((data_byte >= LeadLoB) && (data_byte <= LeadHiB));
   assign is_ctrl = (data_byte < CtrlLimit) || (data_byte == DelByte);

   // Join a held lead with its trail, else index by the byte alone
   assign look_index = pend_ff ? {held_ff, data_byte} : {{DataBits{1'b0}}, data_byte};

   // Table writes
   assign ram_we    = accept && (req_tuser == REQ_WRITE);
   assign ram_waddr = table_index[ADDR_BITS-1:0];
   assign ram_wdata = table_value[CP_BITS-1:0];
   assign ram_raddr = look_index[ADDR_BITS-1:0];

   // Decide the fate of a convert word
   always_comb begin
      stage_in = stage_ff;
      pend_in  = pend_ff;
      held_in  = held_ff;
      ram_re   = 1'b0;
      if (stage_take) begin
         stage_in.valid = 1'b0;
      end
      if (convert) begin
         if (pend_ff) begin
            ram_re         = 1'b1;
            stage_in.valid = 1'b1;
            stage_in.kind  = KIND_LOOKUP;
            pend_in        = 1'b0;
            held_in        = '0;
         end else if (is_lead && req_tlast) begin
            stage_in.valid = 1'b1;
            stage_in.kind  = KIND_TRUNC;
         end else if (is_lead) begin
            pend_in = 1'b1;
            held_in = data_byte;
         end else if (is_ctrl) begin
            stage_in.valid   = 1'b1;
            stage_in.kind    = KIND_LITERAL;
            stage_in.literal = data_byte;
         end else begin
            ram_re         = 1'b1;
            stage_in.valid = 1'b1;
            stage_in.kind  = KIND_LOOKUP;
         end
      end
   end

   // Lead state and lookup stage
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
         pend_ff        <= 1'b0;
         held_ff        <= '0;
      end else begin
         stage_ff.valid <= stage_in.valid;
         pend_ff        <= pend_in;
         held_ff        <= held_in;
      end
      stage_ff.kind    <= stage_in.kind;
      stage_ff.literal <= stage_in.literal;
   end

   assign stage = stage_ff;

   // A waiting lookup must not lose its word or be overwritten by a new read
   `S2U_ASSERT_NEXT(a_stage_holds, stage_ff.valid && !stage_take, stage_ff.valid && $stable(stage_ff.kind), "lookup stage dropped a waiting word")
   `S2U_ASSERT_NOW(a_no_read_while_held, stage_ff.valid && !stage_take, !ram_re, "table read issued over a held lookup")

endmodule

`default_nettype wire

/* hw/rtl/s2u_encode.sv */
`default_nettype none

module s2u_encode #(
   parameter int CP_BITS = 21
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire s2u_pkg::stage_type             stage,
   input  wire logic [CP_BITS-1:0]             ram_rdata,
   output logic                                stage_take,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic      [s2u_pkg::DataBits-1:0]   rsp_tdata,
   output logic                                rsp_tlast,
   output logic      [s2u_pkg::StatusBits-1:0] rsp_tuser
);

   import s2u_pkg::*;

   `include "sjis_to_utf8_stream_assert.svh"

   localparam int Slots = 4;

   logic [ValueBits-1:0]  cp;
   logic [DataBits-1:0]   enc_byte [Slots];
   logic [2:0]            enc_cnt;
   logic [StatusBits-1:0] enc_st;
   logic                  rsp_take;

   logic [DataBits-1:0]   byte_ff [Slots];
   logic [DataBits-1:0]   byte_in [Slots];
   logic [2:0]            cnt_ff, cnt_in;
   logic [StatusBits-1:0] st_ff, st_in;

   // Code point from the table or straight from the byte
   assign cp = (stage.kind == KIND_LITERAL) ? ValueBits'(stage.literal) :
                                              ValueBits'(ram_rdata);

   // Encode the code point into up to four bytes, or flag a truncation or range error
   always_comb begin
      for (int i = 0; i < Slots; i++) begin
         enc_byte[i] = '0;
      end
      enc_cnt = 3'd1;
      enc_st  = ST_OK;
      if (stage.kind == KIND_TRUNC) begin
         enc_st = ST_TRUNC;
      end else if (cp <= Max1Byte) begin
         enc_byte[0] = cp[7:0];
      end else if (cp <= Max2Byte) begin
         enc_byte[0] = Pfx2Byte | {3'b000, cp[10:6]};
         enc_byte[1] = PfxCont  | {2'b00, cp[5:0]};
         enc_cnt     = 3'd2;
      end else if (cp <= Max3Byte) begin
         enc_byte[0] = Pfx3Byte | {4'b0000, cp[15:12]};
         enc_byte[1] = PfxCont  | {2'b00, cp[11:6]};
         enc_byte[2] = PfxCont  | {2'b00, cp[5:0]};
         enc_cnt     = 3'd3;
      end else if (cp <= MaxCodePoint) begin
         enc_byte[0] = Pfx4Byte | {5'b00000, cp[20:18]};
         enc_byte[1] = PfxCont  | {2'b00, cp[17:12]};
         enc_byte[2] = PfxCont  | {2'b00, cp[11:6]};
         enc_byte[3] = PfxCont  | {2'b00, cp[5:0]};
         enc_cnt     = 3'd4;
      end else begin
         enc_st = ST_RANGE;
      end
   end

   // Result word is the head of the byte queue
   assign rsp_tvalid = (cnt_ff != 3'd0);
   assign rsp_tdata  = byte_ff[0];
   assign rsp_tlast  = (cnt_ff == 3'd1);
   assign rsp_tuser  = st_ff;
   assign rsp_take   = rsp_tvalid && rsp_tready;

   // Load a new character once the last byte of the previous one leaves
   assign stage_take = stage.valid &&
                       ((cnt_ff == 3'd0) || ((cnt_ff == 3'd1) && rsp_tready));

   // Load or advance the byte queue
   always_comb begin
      byte_in = byte_ff;
      cnt_in  = cnt_ff;
      st_in   = st_ff;
      if (stage_take) begin
         byte_in = enc_byte;
         cnt_in  = enc_cnt;
         st_in   = enc_st;
      end else if (rsp_take) begin
         for (int i = 0; i < Slots - 1; i++) begin
            byte_in[i] = byte_ff[i+1];
         end
         byte_in[Slots-1] = '0;
         cnt_in           = cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      byte_ff <= byte_in;
      st_ff   <= st_in;
   end

   // Error words stand alone and carry a zero byte
   `S2U_ASSERT_NOW(a_err_alone, rsp_tvalid && rsp_tuser != ST_OK, rsp_tlast && rsp_tdata == 8'h00, "error word not a lone zero byte")
   // A multi-byte character drains without a gap
   `S2U_ASSERT_NEXT(a_char_contiguous, rsp_take && !rsp_tlast, rsp_tvalid && rsp_tuser == ST_OK, "gap inside a character")
   // Queue never holds more than one character
   `S2U_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_ff <= 3'd4, "byte queue overfilled")

endmodule

`default_nettype wire

/* hw/rtl/sjis_to_utf8_stream.sv */
`default_nettype none

// SJIS to UTF-8 stream converter. Each request word is either one
// SJIS byte to convert or one write into the 64K-entry mapping table
// (req_tuser selects). Lead bytes 0x81-0x9F and 0xE0-0xEF are held and joined
// with the next byte as lead<<8|trail; control bytes and 0x7F map to
// themselves; other single bytes index the table by their own value. Each
// character leaves as 1 to 4 UTF-8 response words with tlast on its final
// byte; a lead byte flagged as end of stream, or a code point above 0x10FFFF,
// gives a single zero byte with an error status instead. The table has no
// reset and needs no clearing pass: every entry that is looked up must have
// been written first. Throughput is one request word per cycle while
// characters encode to one byte and rsp_tready stays high; a character of
// several bytes holds the request side while the one-byte-per-cycle response
// queue drains it. The first response byte of a character passes through the
// lookup stage and registered table read, then through the response queue.
module sjis_to_utf8_stream #(
   parameter int TABLE_ENTRIES   = s2u_pkg::TableEntries,
   parameter int CODE_POINT_BITS = s2u_pkg::CodePointBits
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // data_byte[7:0], table_index[23:8], table_value[44:24], zero pad
   input  wire logic [s2u_pkg::ReqDataBits-1:0]  req_tdata,
   // end_of_stream
   input  wire logic                             req_tlast,
   // req_type
   input  wire logic                             req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // out_byte[7:0]
   output logic      [s2u_pkg::DataBits-1:0]     rsp_tdata,
   // last_of_char
   output logic                                  rsp_tlast,
   // status[1:0]
   output logic      [s2u_pkg::StatusBits-1:0]   rsp_tuser
);

   import s2u_pkg::*;

   localparam int AddrBits = $clog2(TABLE_ENTRIES);

   stage_type                  stage;
   logic                       stage_take;
   logic                       ram_we;
   logic [AddrBits-1:0]        ram_waddr;
   logic [CODE_POINT_BITS-1:0] ram_wdata;
   logic                       ram_re;
   logic [AddrBits-1:0]        ram_raddr;
   logic [CODE_POINT_BITS-1:0] ram_rdata;

   // Byte classification, lead holding and table access
   s2u_front #(
      .ADDR_BITS(AddrBits),
      .CP_BITS  (CODE_POINT_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .req_tuser (req_tuser),
      .stage     (stage),
      .stage_take(stage_take),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr)
   );

   // Mapping table
   s2u_ram #(
      .WIDTH(CODE_POINT_BITS),
      .DEPTH(TABLE_ENTRIES)
   ) u_table (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re   (ram_re),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   // UTF-8 encoding and byte-wise output
   s2u_encode #(
      .CP_BITS(CODE_POINT_BITS)
   ) u_encode (
      .clock     (clock),
      .reset     (reset),
      .stage     (stage),
      .ram_rdata (ram_rdata),
      .stage_take(stage_take),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser)
   );

endmodule

`default_nettype wire

/* dv/tb_sjis_to_utf8_stream.sv */
module tb_sjis_to_utf8_stream;
   timeunit 1ns;
   timeprecision 1ps;

   import s2u_pkg::*;

   localparam int IdleLimit  = 3000;
   localparam int SettleWait = 16;

   // One request word as the sender sees it
   typedef struct {
      logic                 kind;
      logic [DataBits-1:0]  data;
      logic                 eos;
      logic [IndexBits-1:0] index;
      logic [ValueBits-1:0] value;
   } sjis_word_type;

   // One UTF-8 response word
   typedef struct packed {
      logic [DataBits-1:0]   out_byte;
      logic                  last_of_char;
      logic [StatusBits-1:0] status;
   } utf8_word_type;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [ReqDataBits-1:0] req_tdata  = '0;
   logic                   req_tlast  = 1'b0;
   logic                   req_tuser  = REQ_CONVERT;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [DataBits-1:0]    rsp_tdata;
   logic                   rsp_tlast;
   logic [StatusBits-1:0]  rsp_tuser;

   // Mirror of the converter state
   logic                 lead_held = 1'b0;
   logic [DataBits-1:0]  held_lead = '0;
   logic [ValueBits-1:0] code_table [TableEntries];
   bit                   code_written [TableEntries];

   utf8_word_type utf8_due [$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int mismatches     = 0;
   int idle_cycles    = 0;
   int n_bytes        = 0;
   int n_writes       = 0;
   int n_checked      = 0;
   int n_trunc        = 0;
   int n_range        = 0;

   sjis_to_utf8_stream dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic is_lead_byte(input logic [DataBits-1:0] b);
      return (b >= LeadLoA && b <= LeadHiA) || (b >= LeadLoB && b <= LeadHiB);
   endfunction

   // Table slot that a convert byte would read in the present state, if any
   function automatic logic table_slot(input logic [DataBits-1:0] b,
                                       output logic [IndexBits-1:0] slot);
      slot = {held_lead, b};
      if (lead_held)
         return 1'b1;
      slot = {8'h00, b};
      if (is_lead_byte(b) || b < CtrlLimit || b == DelByte)
         return 1'b0;
      return 1'b1;
   endfunction

   // Pick a code point from each encoded length, now and then out of range
   function automatic logic [ValueBits-1:0] rand_code_point();
      case ($urandom_range(11))
         0, 1, 2:  return ValueBits'($urandom_range(32'h7f));
         3, 4:     return ValueBits'($urandom_range(32'h7ff, 32'h80));
         5, 6, 7:  return ValueBits'($urandom_range(32'hffff, 32'h800));
         8, 9, 10: return ValueBits'($urandom_range(32'h10ffff, 32'h10000));
         default: return ValueBits'($urandom_range(32'h1fffff, 32'h110000));
      endcase
   endfunction

   task automatic expect_word(input logic [DataBits-1:0] b, input logic last,
                              input logic [StatusBits-1:0] st);
      utf8_word_type w;
      w.out_byte     = b;
      w.last_of_char = last;
      w.status       = st;
      utf8_due.push_back(w);
   endtask

   // Queue the UTF-8 words that one code point turns into
   task automatic expect_code_point(input logic [ValueBits-1:0] cp);
      if (cp <= Max1Byte) begin
         expect_word(cp[7:0], 1'b1, ST_OK);
      end else if (cp <= Max2Byte) begin
         expect_word(Pfx2Byte | {3'b0, cp[10:6]}, 1'b0, ST_OK);
         expect_word(PfxCont | {2'b0, cp[5:0]}, 1'b1, ST_OK);
      end else if (cp <= Max3Byte) begin
         expect_word(Pfx3Byte | {4'b0, cp[15:12]}, 1'b0, ST_OK);
         expect_word(PfxCont | {2'b0, cp[11:6]}, 1'b0, ST_OK);
         expect_word(PfxCont | {2'b0, cp[5:0]}, 1'b1, ST_OK);
      end else if (cp <= MaxCodePoint) begin
         expect_word(Pfx4Byte | {5'b0, cp[20:18]}, 1'b0, ST_OK);
         expect_word(PfxCont | {2'b0, cp[17:12]}, 1'b0, ST_OK);
         expect_word(PfxCont | {2'b0, cp[11:6]}, 1'b0, ST_OK);
         expect_word(PfxCont | {2'b0, cp[5:0]}, 1'b1, ST_OK);
      end else begin
         n_range++;
         expect_word('0, 1'b1, ST_RANGE);
      end
   endtask

   // Advance the mirror state by one accepted request word
   task automatic convert_sjis_word(input sjis_word_type w);
      if (w.kind == REQ_WRITE) begin
         n_writes++;
         code_table[w.index]   = w.value;
         code_written[w.index] = 1'b1;
      end else begin
         n_bytes++;
         if (lead_held) begin
            lead_held = 1'b0;
            expect_code_point(code_table[{held_lead, w.data}]);
            held_lead = '0;
         end else if (is_lead_byte(w.data)) begin
            if (w.eos) begin
               n_trunc++;
               expect_word('0, 1'b1, ST_TRUNC);
            end else begin
               lead_held = 1'b1;
               held_lead = w.data;
            end
         end else if (w.data < CtrlLimit || w.data == DelByte) begin
            expect_code_point({13'b0, w.data});
         end else begin
            expect_code_point(code_table[{8'h00, w.data}]);
         end
      end
   endtask

   // Offer one word, idling first at the sender's rate, and hold until taken
   task automatic send_word(input sjis_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, w.value, w.index, w.data};
      req_tlast  <= w.eos;
      req_tuser  <= w.kind;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      convert_sjis_word(w);
   endtask

   // Convert word; the table fields carry noise
   task automatic send_byte(input logic [DataBits-1:0] b, input logic eos);
      sjis_word_type w;
      w.kind  = REQ_CONVERT;
      w.data  = b;
      w.eos   = eos;
      w.index = IndexBits'($urandom);
      w.value = ValueBits'($urandom);
      send_word(w);
   endtask

   // Table write word; the byte fields carry noise
   task automatic send_entry(input logic [IndexBits-1:0] index,
                             input logic [ValueBits-1:0] value);
      sjis_word_type w;
      w.kind  = REQ_WRITE;
      w.data  = DataBits'($urandom);
      w.eos   = 1'($urandom_range(1));
      w.index = index;
      w.value = value;
      send_word(w);
   endtask

   // Control bytes and DEL pass straight through, end of stream has no effect
   task automatic test_control_passthrough();
      send_byte(8'h00, 1'b0);
      send_byte(8'h1f, 1'b1);
      send_byte(DelByte, 1'b0);
   endtask

   // Single bytes through the table, across the one-, two- and three-byte encodings
   task automatic test_single_byte_lookup();
      send_entry(16'h0020, 21'h000000);
      send_entry(16'h007e, 21'h00007f);
      send_entry(16'h00a0, 21'h000080);
      send_entry(16'h00df, 21'h0007ff);
      send_entry(16'h00ff, 21'h000800);
      send_entry(16'h0080, 21'h00d800);
      send_byte(8'h20, 1'b0);
      send_byte(8'h7e, 1'b0);
      send_byte(8'ha0, 1'b0);
      send_byte(8'hdf, 1'b0);
      send_byte(8'hff, 1'b1);
      send_byte(8'h80, 1'b0);
   endtask

   // Lead and trail pairs: range edges, trail with end of stream, trail in
   // the lead range, and a table write between lead and trail
   task automatic test_double_byte_lookup();
      send_entry(16'h8100, 21'h010000);
      send_entry(16'h9fff, 21'h10ffff);
      send_entry(16'he081, 21'h110000);
      send_byte(8'h81, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h9f, 1'b0);
      send_byte(8'hff, 1'b1);
      send_byte(8'he0, 1'b0);
      send_byte(8'h81, 1'b0);
      send_byte(8'hef, 1'b0);
      send_entry(16'hef7f, 21'h1fffff);
      send_byte(DelByte, 1'b0);
   endtask

   // Lead at end of stream gives a truncation error and holds nothing
   task automatic test_truncated_lead();
      send_byte(8'h81, 1'b1);
      send_byte(8'hef, 1'b1);
      send_byte(8'h7e, 1'b0);
   endtask

   // Mostly well-formed text; lead bytes are favoured so pairs form often,
   // and any entry the next byte would read is loaded first
   task automatic test_random_text(input int n_words);
      logic [DataBits-1:0]  b;
      logic [IndexBits-1:0] slot;
      int                   roll;
      repeat (n_words) begin
         roll = $urandom_range(99);
         if (roll < 12) begin
            send_entry(IndexBits'($urandom), rand_code_point());
         end else begin
            if (roll < 52)
               b = $urandom_range(1) ? DataBits'($urandom_range(LeadHiA, LeadLoA))
                                     : DataBits'($urandom_range(LeadHiB, LeadLoB));
            else
               b = DataBits'($urandom_range(255));
            if (table_slot(b, slot) && !code_written[slot])
               send_entry(slot, rand_code_point());
            send_byte(b, $urandom_range(9) == 0);
         end
      end
   endtask

   // Take response words at the receiver's rate and check each one
   always @(posedge clock) begin
      utf8_word_type got;
      utf8_word_type exp_w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.out_byte     = rsp_tdata;
         got.last_of_char = rsp_tlast;
         got.status       = rsp_tuser;
         if (utf8_due.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected word expected none, actual byte=%h last=%b status=%0d",
                     $realtime, got.out_byte, got.last_of_char, got.status);
         end else begin
            exp_w = utf8_due.pop_front();
            n_checked++;
            if (got.out_byte !== exp_w.out_byte || got.last_of_char !== exp_w.last_of_char
                || got.status !== exp_w.status) begin
               mismatches++;
               $display("%0t: mismatch expected byte=%h last=%b status=%0d", $realtime,
                        exp_w.out_byte, exp_w.last_of_char, exp_w.status);
               $display("%0t:            actual byte=%h last=%b status=%0d", $realtime,
                        got.out_byte, got.last_of_char, got.status);
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // End the run when nothing has moved on either side for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("%0t: no word moved for %0d cycles", $realtime, IdleLimit);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct  = 21;
      recv_stall_pct = 82;
      test_control_passthrough();
      test_single_byte_lookup();
      test_double_byte_lookup();
      test_truncated_lead();
      test_random_text(35);

      send_idle_pct  = 82;
      recv_stall_pct = 21;
      test_random_text(35);

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      test_random_text(35);
      req_tvalid <= 1'b0;

      // Drain the outstanding words, then watch for strays
      while (utf8_due.size() != 0)
         @(posedge clock);
      repeat (SettleWait) @(posedge clock);

      $display("Converted %0d SJIS bytes after %0d table writes; %0d UTF-8 words checked.",
               n_bytes, n_writes, n_checked);
      $display("Truncated leads: %0d, out-of-range code points: %0d.", n_trunc, n_range);
      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
